// ----- design/epcrpm_pkg.sv -----
// ----------------------------------------------------------------------------
// Encoder pulse counter package
// Shared constants, request codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package epcrpm_pkg;

  localparam logic [15:0] PprReset    = 16'd374;
  localparam logic [15:0] MsPerMinute = 16'd60000;
  localparam logic [15:0] RpmMax      = 16'hFFFF;

  typedef enum logic [1:0] {
    ReqEdge  = 2'd0,
    ReqClear = 2'd1,
    ReqRpm   = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    StIdle,
    StMulDiv,
    StMulNum,
    StCheck,
    StMod,
    StDivCheck,
    StDiv,
    StDone
  } state_e;

endpackage

`default_nettype wire

// ----- design/encoder_pulse_counter_rpm.sv -----
// ----------------------------------------------------------------------------
// Encoder pulse counter with RPM measurement
// Edge, clear and zero-window transactions: result in the cycle after
// accept, one transaction per cycle when not stalled. RPM: bit-serial
// sequencer: divisor multiply, numerator multiply, check, remainder by 60000
// (clamp only), saturation check, divide, output, then next input.
// Async active-low reset: count 0, direction forward, pulses_per_rev 374.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_pulse_counter_rpm (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic        phase_b_i,
  input  wire logic [15:0] period_ms_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      pulse_count_o,
  output logic             direction_o,
  output logic [15:0]      rpm_o
);
  import epcrpm_pkg::*;

  state_e      state_q, state_d;
  logic [4:0]  step_q, step_d;
  logic [31:0] count_q, count_d;
  logic        dir_q, dir_d;
  logic [15:0] ppr_q;
  logic [15:0] period_q, period_d;
  logic [31:0] pulses_q, pulses_d;
  logic [31:0] div_q, div_d;
  logic [47:0] acc_q, acc_d;
  logic [31:0] num_q, num_d;
  logic [31:0] rem_q, rem_d;
  logic [15:0] quo_q, quo_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_count_q, out_count_d;
  logic        out_dir_q, out_dir_d;
  logic [15:0] out_rpm_q, out_rpm_d;

  logic        accept;
  logic        out_free;
  logic [31:0] mul_d_sum;
  logic [47:0] mul_n_sum;
  logic [31:0] half;
  logic [47:0] num_sum;
  logic [17:0] mod_t;
  logic [17:0] mod_r;
  logic [32:0] div_t;
  logic        div_ge;
  logic [32:0] div_r;

  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || !out_stall_i;
  assign in_stall_o    = (state_q != StIdle) || !out_free;
  assign accept        = in_valid_i && !in_stall_o;
  assign out_valid_o   = out_valid_q;
  assign pulse_count_o = out_count_q;
  assign direction_o   = out_dir_q;
  assign rpm_o         = out_rpm_q;

  assign mul_d_sum = {div_q[30:0], 1'b0} + (period_q[15] ? {16'b0, ppr_q} : 32'b0);
  assign mul_n_sum = {acc_q[46:0], 1'b0}
                   + (MsPerMinute[~step_q[3:0]] ? {16'b0, pulses_q} : 48'b0);
  assign half      = {1'b0, div_q[31:1]};
  assign num_sum   = acc_q + {16'b0, half};
  assign mod_t     = {rem_q[16:0], num_q[31]};
  assign mod_r     = (mod_t >= {2'b0, MsPerMinute}) ? mod_t - {2'b0, MsPerMinute} : mod_t;
  assign div_t     = {rem_q, num_q[15]};
  assign div_ge    = div_t >= {1'b0, div_q};
  assign div_r     = div_ge ? div_t - {1'b0, div_q} : div_t;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    count_d     = count_q;
    dir_d       = dir_q;
    period_d    = period_q;
    pulses_d    = pulses_q;
    div_d       = div_q;
    acc_d       = acc_q;
    num_d       = num_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_count_d = out_count_q;
    out_dir_d   = out_dir_q;
    out_rpm_d   = out_rpm_q;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          out_valid_d = 1'b1;
          out_dir_d   = dir_q;
          out_count_d = count_q;
          out_rpm_d   = 16'b0;
          case (req_type_i)
            ReqEdge: begin
              count_d     = count_q + 32'd1;
              dir_d       = phase_b_i;
              out_count_d = count_q + 32'd1;
              out_dir_d   = phase_b_i;
            end
            ReqClear: begin
              count_d     = 32'b0;
              out_count_d = 32'b0;
            end
            ReqRpm: begin
              if (period_ms_i != 16'b0) begin
                out_valid_d = 1'b0;
                pulses_d    = count_q;
                count_d     = 32'b0;
                period_d    = period_ms_i;
                div_d       = 32'b0;
                step_d      = 5'b0;
                state_d     = StMulDiv;
              end
            end
            default: ;
          endcase
        end
      end
      StMulDiv: begin
        div_d    = mul_d_sum;
        period_d = {period_q[14:0], 1'b0};
        step_d   = step_q + 5'd1;
        if (step_q == 5'd15) begin
          acc_d   = 48'b0;
          step_d  = 5'b0;
          state_d = StMulNum;
        end
      end
      StMulNum: begin
        acc_d  = mul_n_sum;
        step_d = step_q + 5'd1;
        if (step_q == 5'd15) begin
          step_d  = 5'b0;
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (div_q == 32'b0) begin
          quo_d   = RpmMax;
          state_d = StDone;
        end else if (num_sum[47:32] != 16'b0) begin
          num_d   = ~half;
          rem_d   = 32'b0;
          step_d  = 5'b0;
          state_d = StMod;
        end else begin
          num_d   = num_sum[31:0];
          state_d = StDivCheck;
        end
      end
      StMod: begin
        rem_d  = {15'b0, mod_r[16:0]};
        num_d  = {num_q[30:0], 1'b0};
        step_d = step_q + 5'd1;
        if (step_q == 5'd31) begin
          num_d   = ~{15'b0, mod_r[16:0]};
          state_d = StDivCheck;
        end
      end
      StDivCheck: begin
        if ({16'b0, num_q[31:16]} >= div_q) begin
          quo_d   = RpmMax;
          state_d = StDone;
        end else begin
          rem_d   = {16'b0, num_q[31:16]};
          quo_d   = 16'b0;
          step_d  = 5'b0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        rem_d  = div_r[31:0];
        quo_d  = {quo_q[14:0], div_ge};
        num_d  = {num_q[30:0], 1'b0};
        step_d = step_q + 5'd1;
        if (step_q == 5'd15) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_count_d = count_q;
          out_dir_d   = dir_q;
          out_rpm_d   = quo_q;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= 5'b0;
      count_q     <= 32'b0;
      dir_q       <= 1'b0;
      ppr_q       <= PprReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      count_q     <= count_d;
      dir_q       <= dir_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        ppr_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    period_q    <= period_d;
    pulses_q    <= pulses_d;
    div_q       <= div_d;
    acc_q       <= acc_d;
    num_q       <= num_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    out_count_q <= out_count_d;
    out_dir_q   <= out_dir_d;
    out_rpm_q   <= out_rpm_d;
  end

endmodule

`default_nettype wire
